### sv/sscp_pkg.sv
// ============================================================================
// sscp_pkg
// Shared types, character codes and helper functions for the serial
// setting command parser.
// ============================================================================
package sscp_pkg;

    // Command letters (ASCII)
    localparam logic [7:0] CMD_V = 8'h56;  // average speed
    localparam logic [7:0] CMD_D = 8'h44;  // derivative gain
    localparam logic [7:0] CMD_P = 8'h50;  // proportional gain
    localparam logic [7:0] CMD_I = 8'h49;  // info, no effect here
    localparam logic [7:0] CMD_T = 8'h54;  // drive timing
    localparam logic [7:0] CMD_S = 8'h53;  // system codes
    localparam logic [7:0] CMD_X = 8'h58;  // offsets

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    // S codes as {tens, units} BCD
    localparam logic [7:0] S_SAVE   = 8'h15;
    localparam logic [7:0] S_RUN    = 8'h20;
    localparam logic [7:0] S_STOP   = 8'h25;
    localparam logic [7:0] S_COLOR0 = 8'h50;
    localparam logic [7:0] S_COLOR1 = 8'h55;

    localparam logic [7:0] OFFSET_STEP = 8'd20;
    localparam logic [7:0] OFFSET_BIAS = 8'd100;  // 20 * 5
    localparam logic [6:0] TENS_WEIGHT = 7'd10;

    localparam int VAL_W = 7;
    localparam int OFS_W = 8;

    typedef struct packed {
        logic [VAL_W-1:0]        speed;
        logic [VAL_W-1:0]        prop;
        logic [VAL_W-1:0]        deriv;
        logic [VAL_W-1:0]        drive;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic                    run;
        logic                    color;
    } t_settings;

    typedef struct packed {
        t_settings set;
        logic      save;
        logic      report;
    } t_result;

    function automatic logic is_cmd(input logic [7:0] c);
        return (c == CMD_V) || (c == CMD_D) || (c == CMD_P) || (c == CMD_I) ||
               (c == CMD_T) || (c == CMD_S) || (c == CMD_X);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

    // 20*(d-5), two's complement
    function automatic logic signed [OFS_W-1:0] offset_of(input logic [3:0] d);
        logic [7:0] prod;
        prod = {4'b0000, d} * OFFSET_STEP;
        return signed'(prod - OFFSET_BIAS);
    endfunction

endpackage

### sv/sscp_if.sv
// ============================================================================
// sscp_if
// Valid/ready channels: received byte in, settings word out.
// ============================================================================
interface sscp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sscp_set_if;
    logic                                 valid;
    logic                                 ready;
    logic [sscp_pkg::VAL_W-1:0]           speed_setting;
    logic [sscp_pkg::VAL_W-1:0]           prop_gain;
    logic [sscp_pkg::VAL_W-1:0]           deriv_gain;
    logic [sscp_pkg::VAL_W-1:0]           drive_setting;
    logic signed [sscp_pkg::OFS_W-1:0]    offset_x;
    logic signed [sscp_pkg::OFS_W-1:0]    offset_y;
    logic                                 run_enable;
    logic                                 line_color;
    logic                                 save_pulse;
    logic                                 report_request;

    modport source (
        output valid, output speed_setting, output prop_gain, output deriv_gain,
        output drive_setting, output offset_x, output offset_y, output run_enable,
        output line_color, output save_pulse, output report_request,
        input ready
    );
    modport sink (
        input valid, input speed_setting, input prop_gain, input deriv_gain,
        input drive_setting, input offset_x, input offset_y, input run_enable,
        input line_color, input save_pulse, input report_request,
        output ready
    );
endinterface

### sv/serial_setting_command_parser_core.sv
// ============================================================================
// serial_setting_command_parser_core
// Frames received ASCII bytes into letter+two-digit commands and keeps the
// resulting settings; emits one settings word per received byte.
// ============================================================================
// The settings word for an accepted byte is registered onto o_set in the next cycle.
// Throughput: 1 byte per cycle; the only limit is the output register,
//   which refills in the cycle it is taken (ready = out empty or taken).
// Reset (i_rst_n low, synchronous): frame position, captured bytes and all
//   settings go to zero; the output register is emptied.
// ============================================================================
module serial_setting_command_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sscp_byte_if.sink          i_rx,
    sscp_set_if.source         o_set
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [1:0]           r_pos, n_pos;        // byte position in frame, wraps 0..3
    logic [7:0]           r_first, n_first;    // command letter slot
    logic [7:0]           r_second, n_second;  // tens digit slot
    sscp_pkg::t_settings  r_set, n_set;        // held settings
    logic                 r_out_valid;
    sscp_pkg::t_result    r_out, n_out;        // registered result word

    logic       accept;
    logic [7:0] b;
    logic       b_cmd;
    logic [1:0] pos_eff;
    logic       frame_ok;
    logic [3:0] td;
    logic [3:0] ud;
    logic [6:0] val;
    logic       save;
    logic       report;

    // Output register frees up in the same cycle it is taken.
    assign i_rx.ready = !r_out_valid || o_set.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    assign b      = i_rx.rx_byte;
    assign b_cmd  = sscp_pkg::is_cmd(b);
    // A command letter always restarts the frame.
    assign pos_eff = b_cmd ? 2'd0 : r_pos;

    // Digits are 0x30..0x39, so the low nibble is the value.
    assign td  = r_second[3:0];
    assign ud  = b[3:0];
    assign val = 7'({3'b000, td} * sscp_pkg::TENS_WEIGHT) + {3'b000, ud};

    assign frame_ok = sscp_pkg::is_cmd(r_first) && sscp_pkg::is_digit(r_second)
                      && sscp_pkg::is_digit(b);

    // ------------------------------------------------------------------
    // Frame capture and decode
    // ------------------------------------------------------------------
    always_comb begin
        n_pos    = pos_eff + 2'd1;
        n_first  = r_first;
        n_second = r_second;
        n_set    = r_set;
        save     = 1'b0;
        report   = 1'b0;

        unique case (pos_eff)
            2'd0: begin
                n_first = b;
            end
            2'd1: begin
                n_second = b;
            end
            2'd2: begin
                if (frame_ok) begin
                    unique case (r_first)
                        sscp_pkg::CMD_V: begin
                            n_set.speed = val;
                            report      = 1'b1;
                        end
                        sscp_pkg::CMD_P: begin
                            n_set.prop = val;
                            report     = 1'b1;
                        end
                        sscp_pkg::CMD_D: begin
                            n_set.deriv = val;
                            report      = 1'b1;
                        end
                        sscp_pkg::CMD_T: begin
                            n_set.drive = val;
                            report      = 1'b1;
                        end
                        sscp_pkg::CMD_X: begin
                            // units digit sets X, tens digit sets Y
                            n_set.offset_x = sscp_pkg::offset_of(ud);
                            n_set.offset_y = sscp_pkg::offset_of(td);
                        end
                        sscp_pkg::CMD_S: begin
                            unique case ({td, ud})
                                sscp_pkg::S_SAVE: begin
                                    save   = 1'b1;
                                    report = 1'b1;
                                end
                                sscp_pkg::S_RUN: begin
                                    n_set.run = 1'b1;
                                    report    = 1'b1;
                                end
                                sscp_pkg::S_STOP: begin
                                    n_set.run = 1'b0;
                                    report    = 1'b1;
                                end
                                sscp_pkg::S_COLOR0: begin
                                    n_set.color = 1'b0;
                                end
                                sscp_pkg::S_COLOR1: begin
                                    n_set.color = 1'b1;
                                end
                                default: begin
                                    // other S codes are quiet
                                end
                            endcase
                        end
                        default: begin
                            // I: no effect
                        end
                    endcase
                end
            end
            default: begin
                // fourth byte is dropped
            end
        endcase

        n_out.set    = n_set;
        n_out.save   = save;
        n_out.report = report;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_first     <= '0;
            r_second    <= '0;
            r_set       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos    <= n_pos;
                r_first  <= n_first;
                r_second <= n_second;
                r_set    <= n_set;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_set.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------
    assign o_set.valid          = r_out_valid;
    assign o_set.speed_setting  = r_out.set.speed;
    assign o_set.prop_gain      = r_out.set.prop;
    assign o_set.deriv_gain     = r_out.set.deriv;
    assign o_set.drive_setting  = r_out.set.drive;
    assign o_set.offset_x       = r_out.set.offset_x;
    assign o_set.offset_y       = r_out.set.offset_y;
    assign o_set.run_enable     = r_out.set.run;
    assign o_set.line_color     = r_out.set.color;
    assign o_set.save_pulse     = r_out.save;
    assign o_set.report_request = r_out.report;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_save_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_set.valid && o_set.save_pulse) |-> o_set.report_request)
        else $error("save pulse without report request");

    a_letter_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && b_cmd) |=> (r_pos == 2'd1) && (r_first == $past(b)))
        else $error("command letter did not restart frame");

    a_settings_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_set) && $stable(r_pos))
        else $error("state changed without an accepted byte");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_set.ready) |-> !i_rx.ready)
        else $error("input taken while result stalled");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out.set == r_set))
        else $error("result word does not match held settings");

endmodule
